### rtl/iida_pkg.sv
// Package for the indexed insert/delete array.
// Holds the sizes, the request and status codes, and the command that is broadcast to the cells.
// No dependencies.
package iida_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = 5;                  // index and count field width
	localparam int SEL_W    = $clog2(CAPACITY);   // bits that pick one cell
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} cell_op_t;

	// Broadcast to every cell in the row
	typedef struct packed {
		cell_op_t                  op;
		logic [IDX_W-1:0]          idx;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

endpackage

### rtl/iida_cell.sv
// One storage cell of the indexed insert/delete array.
// Holds one word and takes its left or right neighbor's word on a shift.
// Depends on iida_pkg.
module iida_cell (
	input  logic                              clk,
	input  iida_pkg::cell_cmd_t               cmd,
	input  logic [iida_pkg::IDX_W-1:0]        pos,
	input  logic signed [iida_pkg::DATA_W-1:0] left_data,
	input  logic signed [iida_pkg::DATA_W-1:0] right_data,
	output logic signed [iida_pkg::DATA_W-1:0] data
);
	import iida_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				// take the new word at the slot, shift up above it
				if (pos == cmd.idx) begin
					data_q <= cmd.value;
				end else if (pos > cmd.idx) begin
					data_q <= left_data;
				end
			end
			OP_DELETE: begin
				// close the gap: every slot from the index up takes its right neighbor
				if (pos >= cmd.idx) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

### rtl/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array.
// Holds the fill count, the request decode, the read select and the result register;
// instantiates a row of iida_cell. Depends on iida_pkg.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  request | in_valid, in_ready, mode, index, value   | in
//  result  | out_valid, out_ready, read_data, status, | out
//          | element_count                            |
//
// One request completes per cycle unless the result is stalled: the decode, the read select
// over the cells and the fill count update all settle in the cycle of the transfer, and the
// result is registered at the edge that ends it; insert and delete shift all cells in that same edge.
// A request is taken while the result register is empty or being drained, so a stalled
// result holds the input side back without dropping anything.
// Reset clears the fill count and the result valid; cell contents stay undefined and are
// never read before being written.
module indexed_insert_delete_array (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           mode,
	input  logic [iida_pkg::IDX_W-1:0]           index,
	input  logic signed [iida_pkg::DATA_W-1:0]   value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [iida_pkg::DATA_W-1:0]   read_data,
	output logic [1:0]                           status,
	output logic [iida_pkg::IDX_W-1:0]           element_count
);
	import iida_pkg::*;

	logic [IDX_W-1:0]          count_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  read_data_q;
	status_t                   status_q;
	logic [IDX_W-1:0]          element_count_q;

	logic                      accept;
	logic                      full;
	cell_cmd_t                 cmd;
	status_t                   st_next;
	logic signed [DATA_W-1:0]  rd_next;
	logic [IDX_W-1:0]          count_next;
	logic signed [DATA_W-1:0]  cell_data [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == IDX_W'(CAPACITY));

	// Decode the request against the current fill count
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.idx    = index;
		cmd.value  = value;
		st_next    = ST_OK;
		rd_next    = '0;
		count_next = count_q;
		case (mode)
			MODE_APPEND: begin
				// append is an insert at the end
				cmd.idx = count_q;
				if (full) begin
					st_next = ST_FULL;
				end else begin
					cmd.op     = OP_INSERT;
					count_next = count_q + IDX_W'(1);
				end
			end
			MODE_INSERT: begin
				if (index > count_q) begin
					st_next = ST_RANGE;
				end else if (full) begin
					st_next = ST_FULL;
				end else begin
					cmd.op     = OP_INSERT;
					count_next = count_q + IDX_W'(1);
				end
			end
			MODE_DELETE: begin
				if (index >= count_q) begin
					st_next = ST_RANGE;
				end else begin
					cmd.op     = OP_DELETE;
					count_next = count_q - IDX_W'(1);
				end
			end
			default: begin
				if (index >= count_q) begin
					st_next = ST_RANGE;
					rd_next = -32'sd1;
				end else begin
					rd_next = cell_data[index[SEL_W-1:0]];
				end
			end
		endcase
		// drop the command unless the request is transferred this cycle
		if (!accept) begin
			cmd.op = OP_NONE;
		end
	end

	// Row of cells; the ends see their own word as the missing neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = cell_data[i];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		iida_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (IDX_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load on transfer, hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q     <= rd_next;
			status_q        <= st_next;
			element_count_q <= count_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign status        = status_q;
	assign element_count = element_count_q;

endmodule
